// File: design/coalescing_extent_allocator_core_assert.svh
// assertion macros for the extent allocator
`ifndef COALESCING_EXTENT_ALLOCATOR_CORE_ASSERT_SVH
`define COALESCING_EXTENT_ALLOCATOR_CORE_ASSERT_SVH

// property holds on every clock edge outside reset
`define CEA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in a cycle implies consequent in the next
`define CEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/cea_pkg.sv
package cea_pkg;

  localparam logic OP_FREE  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [15:0] LEN_LIMIT = 16'hFFFF;
  localparam logic [31:0] NULL_PAGE = 32'd0;

  typedef struct packed {
    logic [31:0] start;
    logic [15:0] length;
  } extent_t;

endpackage

// File: design/cea_extent_mem.sv
module cea_extent_mem
  import cea_pkg::*;
#(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  extent_t       wdata,
  input  logic [AW-1:0] raddr,
  output extent_t       rdata
);

  extent_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/coalescing_extent_allocator_core.sv
// Extent allocator: keeps a table of free page extents and a free page total.
// Input channel (in_valid/in_ready): opcode 0 frees count pages at page_id,
// opcode 1 allocates count pages (best fit, lowest start on ties).
// Result channel (out_valid/out_ready): one result per request carrying
// status, granted_page and free_total after the request.
// Each request makes one pass over the extent memory, reading one slot per
// cycle through a single read port; the decide cycle writes the table back
// and registers the result; a zero count skips the pass and is answered
// straight from the output state.
// One request is in work at a time, so a new request is taken only once the
// result of the last one has been registered and taken.
// The result sits in an output register; while the receiver stalls the result
// holds and no new request is accepted until it is taken.
// Reset empties the table (valid bits clear at once) and zeroes the total;
// no clearing pass is needed, start and length storage is left as is.
module coalescing_extent_allocator_core
  import cea_pkg::*;
#(
  parameter int MAX_EXTENTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_page_id,
  input  logic [15:0] in_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_granted_page,
  output logic [31:0] out_free_total
);

  localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0] LAST = CW'(MAX_EXTENTS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic        op_r;
  logic [31:0] pid_r;
  logic [15:0] cnt_r;
  logic [31:0] free_r;
  logic [MAX_EXTENTS-1:0] valid_r;

  // scan counters: issue address and the address of the data arriving
  logic [CW-1:0] ridx_r;
  logic [AW-1:0] didx_r;
  logic          dval_r;

  logic          lf_r, rf_r, sf_r, bf_r;
  logic [AW-1:0] li_r, ri_r, si_r, bi_r;
  extent_t       le_r, re_e_r, be_r;

  logic        ov_r;
  logic [1:0]  st_r;
  logic [31:0] gp_r, ft_r;

  logic          we;
  logic [AW-1:0] waddr;
  extent_t       wdata, rdata;

  cea_extent_mem #(.AW(AW)) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(ridx_r[AW-1:0]),
    .rdata(rdata)
  );

  assign in_ready         = (state_r == S_IDLE) && !ov_r;
  assign out_valid        = ov_r;
  assign out_status       = st_r;
  assign out_granted_page = gp_r;
  assign out_free_total   = ft_r;

  logic cur_valid;
  assign cur_valid = dval_r && valid_r[didx_r];

  // decision logic for the end of a scan
  logic [32:0] lend, rend;
  logic [16:0] len_a, len_b;
  logic        ljoin, rjoin;
  logic        slot_ok;
  logic [AW-1:0] slot;
  logic [15:0] mlen;
  logic [31:0] mstart;
  logic [MAX_EXTENTS-1:0] valid_upd;

  always_comb begin
    lend  = {1'b0, le_r.start} + {17'd0, le_r.length};
    rend  = {1'b0, pid_r} + {17'd0, cnt_r};
    ljoin = lf_r && (lend == {1'b0, pid_r});
    len_a = {1'b0, cnt_r} + {1'b0, le_r.length};
    ljoin = ljoin && (len_a < {1'b0, LEN_LIMIT});
    mlen   = ljoin ? len_a[15:0] : cnt_r;
    mstart = ljoin ? le_r.start : pid_r;
    rjoin = rf_r && (rend == {1'b0, re_e_r.start});
    len_b = {1'b0, mlen} + {1'b0, re_e_r.length};
    rjoin = rjoin && (len_b < {1'b0, LEN_LIMIT});
    if (rjoin) mlen = len_b[15:0];
    slot_ok = sf_r;
    slot    = si_r;
    if (ljoin && (!slot_ok || li_r < slot)) begin
      slot = li_r;
      slot_ok = 1'b1;
    end
    if (rjoin && (!slot_ok || ri_r < slot)) begin
      slot = ri_r;
      slot_ok = 1'b1;
    end
    // joined neighbours leave the table, the merged extent takes the slot
    valid_upd = valid_r;
    if (ljoin) valid_upd[li_r] = 1'b0;
    if (rjoin) valid_upd[ri_r] = 1'b0;
    if (slot_ok) valid_upd[slot] = 1'b1;
  end

  extent_t rem;
  assign rem = {be_r.start + {16'd0, cnt_r}, be_r.length - cnt_r};

  always_comb begin
    state_nxt = state_r;
    we    = 1'b0;
    waddr = slot;
    wdata.start  = mstart;
    wdata.length = mlen;
    case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        if (in_count == 16'd0) state_nxt = S_OUT;
        else state_nxt = S_SCAN;
      end
      S_SCAN: if (!dval_r && ridx_r == CW'(MAX_EXTENTS)) state_nxt = S_DEC;
      S_DEC: begin
        if (op_r == OP_FREE) begin
          we = slot_ok;
          state_nxt = S_OUT;
        end else if (free_r >= {16'd0, cnt_r} && bf_r) begin
          we = 1'b1;
          waddr = bi_r;
          wdata = rem;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      free_r  <= '0;
      ov_r    <= 1'b0;
      dval_r  <= 1'b0;
      ridx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          op_r  <= in_opcode;
          pid_r <= in_page_id;
          cnt_r <= in_count;
          ridx_r <= '0;
          dval_r <= 1'b0;
          lf_r <= 1'b0; rf_r <= 1'b0; sf_r <= 1'b0; bf_r <= 1'b0;
          st_r <= ST_OK;
          gp_r <= NULL_PAGE;
        end
        S_SCAN: begin
          if (ridx_r != CW'(MAX_EXTENTS)) begin
            dval_r <= 1'b1;
            didx_r <= ridx_r[AW-1:0];
            ridx_r <= (ridx_r == LAST) ? CW'(MAX_EXTENTS) : ridx_r + CW'(1);
          end else begin
            dval_r <= 1'b0;
          end
          if (dval_r) begin
            if (!cur_valid) begin
              if (!sf_r) begin
                sf_r <= 1'b1;
                si_r <= didx_r;
              end
            end else if (op_r == OP_FREE) begin
              if (rdata.start <= pid_r) begin
                if (!lf_r || rdata.start > le_r.start) begin
                  lf_r <= 1'b1; li_r <= didx_r; le_r <= rdata;
                end
              end else if (!rf_r || rdata.start < re_e_r.start) begin
                rf_r <= 1'b1; ri_r <= didx_r; re_e_r <= rdata;
              end
            end else if (rdata.length >= cnt_r) begin
              if (!bf_r || rdata.length < be_r.length ||
                  (rdata.length == be_r.length && rdata.start < be_r.start)) begin
                bf_r <= 1'b1; bi_r <= didx_r; be_r <= rdata;
              end
            end
          end
        end
        S_DEC: begin
          ov_r <= 1'b1;
          if (op_r == OP_FREE) begin
            if (slot_ok) begin
              valid_r <= valid_upd;
              free_r <= free_r + {16'd0, cnt_r};
              ft_r   <= free_r + {16'd0, cnt_r};
              st_r   <= ST_OK;
            end else begin
              st_r <= ST_FULL;
              ft_r <= free_r;
            end
          end else if (free_r >= {16'd0, cnt_r} && bf_r) begin
            gp_r <= be_r.start;
            if (rem.length == 16'd0) valid_r[bi_r] <= 1'b0;
            free_r <= free_r - {16'd0, cnt_r};
            ft_r   <= free_r - {16'd0, cnt_r};
            st_r   <= ST_OK;
          end else begin
            st_r <= ST_FAIL;
            ft_r <= free_r;
          end
        end
        S_OUT: if (cnt_r == 16'd0 && !ov_r) begin
          ov_r <= 1'b1;
          ft_r <= free_r;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: design/cea_checker.sv
module cea_checker
  import cea_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_granted_page,
  input logic [31:0] out_free_total
);
`include "coalescing_extent_allocator_core_assert.svh"

  `CEA_ASSERT(a_status_range, !out_valid || out_status != 2'd3, "status code out of range")
  `CEA_ASSERT(a_grant_zero, !out_valid || out_status == ST_OK || out_granted_page == 32'd0, "grant on failure")
  `CEA_ASSERT(a_no_accept_while_out, !(out_valid && in_ready), "accept while result pending")
  `CEA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_free_total), "result dropped")

endmodule

bind coalescing_extent_allocator_core cea_checker u_cea_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_granted_page(out_granted_page), .out_free_total(out_free_total)
);

// File: tb/coalescing_extent_allocator_core_checker.sv
module coalescing_extent_allocator_core_checker
  import cea_pkg::*;
#(
  parameter int MAX_EXTENTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_opcode,
  input  logic [31:0] in_page_id,
  input  logic [15:0] in_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_granted_page,
  input  logic [31:0] out_free_total,
  output int          errors,
  output int          pending,
  output int          n_results,
  output int          n_merges,
  output int          n_full
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted;
    logic [31:0] total;
  } alloc_reply_t;

  extent_t     ext_tbl[MAX_EXTENTS];
  bit          ext_used[MAX_EXTENTS];
  logic [31:0] pages_free;
  alloc_reply_t replies_due[$];

  function automatic logic [1:0] free_extent(logic [31:0] pid, logic [15:0] cnt);
    int lft, rgt, slot;
    logic [16:0] len;
    lft = -1; rgt = -1; slot = -1;
    len = cnt;
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      if (!ext_used[i]) begin
        if (slot < 0) slot = i;
      end else if (ext_tbl[i].start <= pid) begin
        if (lft < 0 || ext_tbl[i].start > ext_tbl[lft].start) lft = i;
      end else begin
        if (rgt < 0 || ext_tbl[i].start < ext_tbl[rgt].start) rgt = i;
      end
    end
    if (lft >= 0 && ({1'b0, ext_tbl[lft].start} + ext_tbl[lft].length) != {1'b0, pid})
      lft = -1;
    if (rgt >= 0 && ({1'b0, pid} + cnt) != {1'b0, ext_tbl[rgt].start}) rgt = -1;
    if (lft >= 0 && len + ext_tbl[lft].length < LEN_LIMIT) begin
      len += ext_tbl[lft].length;
      pid = ext_tbl[lft].start;
      ext_used[lft] = 0;
      if (slot < 0 || lft < slot) slot = lft;
      n_merges++;
    end
    if (rgt >= 0 && len + ext_tbl[rgt].length < LEN_LIMIT) begin
      len += ext_tbl[rgt].length;
      ext_used[rgt] = 0;
      if (slot < 0 || rgt < slot) slot = rgt;
      n_merges++;
    end
    if (slot < 0) begin
      n_full++;
      return ST_FULL;
    end
    ext_tbl[slot].start = pid;
    ext_tbl[slot].length = len[15:0];
    ext_used[slot] = 1;
    pages_free += cnt;
    return ST_OK;
  endfunction

  function automatic logic [1:0] take_extent(logic [15:0] cnt, output logic [31:0] g);
    int best;
    best = -1;
    g = NULL_PAGE;
    if (pages_free < cnt) return ST_FAIL;
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      if (!ext_used[i] || ext_tbl[i].length < cnt) continue;
      if (best < 0 || ext_tbl[i].length < ext_tbl[best].length ||
          (ext_tbl[i].length == ext_tbl[best].length &&
           ext_tbl[i].start < ext_tbl[best].start))
        best = i;
    end
    if (best < 0) return ST_FAIL;
    g = ext_tbl[best].start;
    ext_tbl[best].start += cnt;
    ext_tbl[best].length -= cnt;
    if (ext_tbl[best].length == 0) ext_used[best] = 0;
    pages_free -= cnt;
    return ST_OK;
  endfunction

  always @(posedge clk) begin
    alloc_reply_t r, got;
    if (!rst_n) begin
      for (int i = 0; i < MAX_EXTENTS; i++) ext_used[i] = 0;
      pages_free = 0;
      replies_due.delete();
      errors = 0; n_results = 0; n_merges = 0; n_full = 0;
      pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_status, out_granted_page, out_free_total};
        n_results++;
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          r = replies_due.pop_front();
          if (got.status !== r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, r.status, got.status);
            errors++;
          end
          if (got.granted !== r.granted) begin
            $display("%0t: granted_page expected %h actual %h", $time, r.granted,
                     got.granted);
            errors++;
          end
          if (got.total !== r.total) begin
            $display("%0t: free_total expected %h actual %h", $time, r.total, got.total);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        r.granted = NULL_PAGE;
        r.status = ST_OK;
        if (in_count != 0) begin
          if (in_opcode == OP_FREE) r.status = free_extent(in_page_id, in_count);
          else r.status = take_extent(in_count, r.granted);
        end
        r.total = pages_free;
        replies_due = {replies_due, r};
      end
      pending = replies_due.size();
    end
  end

endmodule

// File: tb/coalescing_extent_allocator_core_test.sv
module coalescing_extent_allocator_core_test;
  import cea_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_opcode = OP_FREE;
  logic [31:0] in_page_id = 0;
  logic [15:0] in_count = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  out_status;
  logic [31:0] out_granted_page;
  logic [31:0] out_free_total;
  int          errors, pending, n_results, n_merges, n_full;
  int          cycles = 0;
  bit          hold_off = 0;
  logic [31:0] next_page = 32'h1000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  coalescing_extent_allocator_core uut (.*);
  coalescing_extent_allocator_core_checker chk (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 150);
  endfunction

  task automatic send_req(logic op, logic [31:0] pid, logic [15:0] cnt);
    @(negedge clk);
    in_valid = 1; in_opcode = op; in_page_id = pid; in_count = cnt;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 0;
    repeat (gap_len()) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready = 0;
        repeat (600) @(negedge clk);
        hold_off = 0;
      end
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      out_ready = (g == 0);
      repeat (g) @(negedge clk);
      out_ready = 1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 1000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int kind;
    logic [15:0] c;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1;
    // directed
    send_req(OP_ALLOC, 0, 1);              // empty table
    send_req(OP_FREE, 32'h100, 0);         // zero count
    send_req(OP_ALLOC, 32'hFFFFFFFF, 0);
    send_req(OP_FREE, 32'h100, 16);
    send_req(OP_FREE, 32'h110, 16);        // joins on the left
    send_req(OP_FREE, 32'h0F0, 16);        // joins on the right
    send_req(OP_FREE, 32'h200, 8);
    send_req(OP_FREE, 32'h1F0, 8);
    send_req(OP_FREE, 32'h1F8, 8);         // fills a hole, both sides
    send_req(OP_ALLOC, 0, 40);             // best fit
    send_req(OP_ALLOC, 0, 16'hFFFF);       // total short
    send_req(OP_FREE, 32'h0, 16'hFFFF);
    send_req(OP_FREE, 32'hFFFF, 1);        // page just past a 65535-page extent
    send_req(OP_FREE, 32'hFFFFFFF0, 16);   // end of address space
    send_req(OP_FREE, 32'hFFFF0000, 16'hFFFE);
    send_req(OP_ALLOC, 0, 16'hFFFE);
    send_req(OP_ALLOC, 0, 16);             // remainder start wraps
    send_req(OP_ALLOC, 0, 16'hFFFF);
    send_req(OP_FREE, 32'hAAAA5555, 16'h5555);
    send_req(OP_ALLOC, 0, 16'hAAAA);
    // fill the table with isolated extents to reach table full
    for (int i = 0; i < 70; i++) send_req(OP_FREE, 32'h4000_0000 + 32'(i * 4), 1);
    wait_drained();
    // long receiver hold-off while the sender keeps going
    @(negedge clk) hold_off = 1;
    for (int i = 0; i < 60; i++) send_req(OP_ALLOC, 0, 16'($urandom_range(1, 3)));
    wait_drained();
    for (int i = 0; i < 300; i++) begin
      kind = $urandom_range(0, 9);
      c = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 64));
      if (kind < 4) begin
        send_req(OP_FREE, next_page, c);
        if ($urandom_range(0, 1)) next_page += 32'(c);
        else next_page += 32'(c) + $urandom_range(1, 40);
      end else if (kind < 8) begin
        send_req(OP_ALLOC, $urandom, ($urandom_range(0, 3) == 0) ? c : 16'($urandom_range(1, 8)));
      end else begin
        send_req(kind[0], $urandom, ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom));
      end
      if (i == 150) wait_drained();
    end
    wait_drained();
    repeat (100) @(negedge clk);
    $display("run covered %0d results, %0d neighbor joins, %0d table-full frees",
             n_results, n_merges, n_full);
    if (errors == 0 && pending == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/cea_pkg.sv
design/cea_extent_mem.sv
design/coalescing_extent_allocator_core.sv
design/cea_checker.sv
tb/coalescing_extent_allocator_core_checker.sv
tb/coalescing_extent_allocator_core_test.sv
